>>> hw/rtl/pdc_pkg.sv
// pdc_pkg: shared types and constants for the pair difference counter
// holds beat structs, the token passed along the cell chain and match setup
// no dependencies
package pdc_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 15;
    localparam int DIFF_W       = DATA_W + 1;

    localparam logic [COUNT_W-1:0] PAIR_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_beat_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pair_count;
        logic               overflow;
    } out_beat_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
    } token_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] pos_diff;
        logic signed [DIFF_W-1:0] neg_diff;
        logic                     enable;
    } match_cfg_t;

endpackage

>>> hw/rtl/pair_difference_counter_core.sv
// pair_difference_counter_core: top level of the pair difference counter
// sequencer, difference register and a chain of pdc_cell instances
// depends on pdc_pkg and pdc_cell
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | in_data (in_beat_t)
//   out     | output    | out_valid/out_ready| out_data (out_beat_t)
//   cfg     | input     | cfg_we             | cfg_wdata (difference)
//
// an item is taken only while idle; the token walks one cell per cycle down the
// chain until it lands in the first free cell
// an item marked last then passes through the flush state to load the result register
// an item arriving with the set full is dropped and sets the overflow flag
// reset clears the sequencer and set state, stored values need no clearing
// a result that is not taken holds the next set end until out_ready
module pair_difference_counter_core
    import pdc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_beat_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_beat_t                out_data,
    input  logic                     cfg_we,
    input  logic signed [DATA_W-1:0] cfg_wdata
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int STATE_W = 2;

    localparam logic [STATE_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [STATE_W-1:0] ST_BUSY  = 2'd1;
    localparam logic [STATE_W-1:0] ST_FLUSH = 2'd2;

    logic [STATE_W-1:0]       state_reg,     state_next;
    logic [CNT_W-1:0]         fill_reg,      fill_next;
    logic [COUNT_W-1:0]       pairs_reg,     pairs_next;
    logic                     dropped_reg,   dropped_next;
    logic                     last_reg,      last_next;
    logic                     out_valid_reg, out_valid_next;
    out_beat_t                out_data_reg,  out_data_next;
    token_t                   inject_reg,    inject_next;
    logic signed [DATA_W-1:0] difference_reg;

    match_cfg_t match;
    token_t     link [0:CAPACITY];
    token_t     tail_tok;
    logic       in_fire;

    assign match.pos_diff = {difference_reg[DATA_W-1], difference_reg};
    assign match.neg_diff = -{difference_reg[DATA_W-1], difference_reg};
    assign match.enable   = !difference_reg[DATA_W-1];

    assign link[0] = inject_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            pdc_cell #(
                .CAPACITY (CAPACITY),
                .INDEX    (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .tok_in     (link[gi]),
                .tok_out    (link[gi+1]),
                .fill_count (fill_reg),
                .match      (match)
            );
        end
    endgenerate

    assign tail_tok = link[fill_reg];
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        pairs_next     = pairs_reg;
        dropped_next   = dropped_reg;
        last_next      = last_reg;
        inject_next    = inject_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        inject_next.valid = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    last_next = in_data.last;
                    if (fill_reg == CNT_W'(CAPACITY))
                    begin
                        dropped_next = 1'b1;
                        state_next   = in_data.last ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        inject_next.valid = 1'b1;
                        inject_next.value = in_data.value;
                        inject_next.count = pairs_reg;
                        state_next        = ST_BUSY;
                    end
                end
            end
            ST_BUSY:
            begin
                if (tail_tok.valid)
                begin
                    pairs_next = tail_tok.count;
                    fill_next  = fill_reg + CNT_W'(1);
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.pair_count = pairs_reg;
                    out_data_next.overflow   = dropped_reg;
                    fill_next                = '0;
                    pairs_next               = '0;
                    dropped_next             = 1'b0;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fill_reg         <= '0;
            pairs_reg        <= '0;
            dropped_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            inject_reg.valid <= 1'b0;
            difference_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pairs_reg     <= pairs_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            inject_reg    <= inject_next;
            if (cfg_we)
            begin
                difference_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/pdc_cell.sv
// pdc_cell: one element of the value chain
// holds one stored value, compares the passing token and bumps the token's running count
// depends on pdc_pkg
module pdc_cell
    import pdc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int INDEX    = 0,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  token_t           tok_in,
    output token_t           tok_out,
    input  logic [CNT_W-1:0] fill_count,
    input  match_cfg_t       match
);

    logic signed [DATA_W-1:0] stored_reg;
    token_t                   tok_reg;
    token_t                   tok_next;
    logic                     store_here;
    logic signed [DIFF_W-1:0] diff;
    logic                     hit;

    assign store_here = (fill_count == CNT_W'(INDEX));
    assign diff = {tok_in.value[DATA_W-1], tok_in.value}
                - {stored_reg[DATA_W-1], stored_reg};
    assign hit = match.enable && ((diff == match.pos_diff) || (diff == match.neg_diff));

    always_comb
    begin
        tok_next       = tok_in;
        tok_next.valid = tok_in.valid && !store_here;
        if (hit && (tok_in.count != PAIR_MAX))
        begin
            tok_next.count = tok_in.count + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in.valid && store_here)
        begin
            stored_reg <= tok_in.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.valid <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
